// File: sv/cmm_pkg.sv
`default_nettype none
package cmm_pkg;

	// Number formats.
	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 16;
	localparam logic [31:0] Q_ONE = 32'd1 << FRAC_BITS;
	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	// Taylor coefficients of sin(pi/2*z) in Q30.
	localparam logic [31:0] C1_Q30 = 32'd1686629713;
	localparam logic [31:0] C3_Q30 = 32'd693598669;
	localparam logic [31:0] C5_Q30 = 32'd85569306;
	localparam logic [31:0] C7_Q30 = 32'd5026995;
	localparam logic [31:0] C9_Q30 = 32'd172272;

	// Request and entry payloads.
	typedef struct packed {
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
		logic [15:0]        turn_x;
		logic [15:0]        turn_y;
		logic [15:0]        turn_z;
		logic signed [31:0] stretch_x;
		logic signed [31:0] stretch_y;
		logic signed [31:0] stretch_z;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic [1:0]         col_index;
		logic signed [31:0] entry_value;
		logic               last_entry;
	} ent_t;

	// Top three rows of a matrix; the bottom row is constant.
	typedef logic [3:0][31:0] row_t;
	typedef row_t [2:0] mat_t;

	// Low ANGLE_BITS bits of a turn field, zero filled above 16 bits.
	function automatic logic [ANGLE_BITS-1:0] turn_angle(input logic [15:0] t);
		logic [31:0] w;
		w = {16'd0, t};
		return w[ANGLE_BITS-1:0];
	endfunction

	// Round half up by sh fraction bits, then saturate to 32 bits.
	function automatic logic [31:0] rnd_sat(input logic signed [64:0] v, input int unsigned sh);
		logic signed [64:0] t;
		t = (v + (65'sd1 <<< (sh - 1))) >>> sh;
		if (t > 65'sd2147483647) begin
			return 32'h7fff_ffff;
		end else if (t < -65'sd2147483648) begin
			return 32'h8000_0000;
		end
		return t[31:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/cmm_sine.sv
`default_nettype none
// Seven-stage sine generator: quadrant fold, z squared, four Horner steps,
// final product with rounding, clamp and sign.
module cmm_sine import cmm_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output logic signed [16:0]    value
);

	logic [1:0]  quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;
	logic [30:0] z_s1, z_s2, z_s3, z_s4, z_s5, z_s6;
	logic [30:0] z2_s2, z2_s3, z2_s4, z2_s5;
	logic [31:0] p_s3, p_s4, p_s5, p_s6;
	logic signed [16:0] q_s7;

	logic [1:0]  quad_c;
	logic [30:0] z_c;
	logic [61:0] sq_c;
	logic [48:0] m3_c;
	logic [62:0] m4_c, m5_c, m6_c, m7_c;
	logic [32:0] s_c;
	logic [18:0] r_c;
	logic signed [16:0] q_c;

	// Fold the angle into a quadrant and an offset in [0, 1] of a quarter turn.
	always_comb begin
		quad_c = angle[ANGLE_BITS-1:ANGLE_BITS-2];
		z_c = 31'(angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
		if (quad_c[0]) begin
			z_c = (31'd1 << 30) - z_c;
		end
	end

	// Horner steps, one multiplication per stage.
	always_comb begin
		sq_c = 62'(z_s1) * 62'(z_s1);
		m3_c = 49'(C9_Q30) * 49'(z2_s2);
		m4_c = 63'(p_s3) * 63'(z2_s3);
		m5_c = 63'(p_s4) * 63'(z2_s4);
		m6_c = 63'(p_s5) * 63'(z2_s5);
		m7_c = 63'(p_s6) * 63'(z_s6);
	end

	// Round to Q15, clamp at one and apply the sign of the lower half turn.
	always_comb begin
		s_c = m7_c[62:30];
		r_c = 19'((34'(s_c) + 34'd16384) >> 15);
		if (r_c > 19'd32768) begin
			q_c = 17'sd32768;
		end else begin
			q_c = 17'(r_c);
		end
		if (quad_s6[1]) begin
			q_c = -q_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= quad_c;
			z_s1    <= z_c;
			quad_s2 <= quad_s1;
			z_s2    <= z_s1;
			z2_s2   <= sq_c[60:30];
			quad_s3 <= quad_s2;
			z_s3    <= z_s2;
			z2_s3   <= z2_s2;
			p_s3    <= C7_Q30 - 32'(m3_c >> 30);
			quad_s4 <= quad_s3;
			z_s4    <= z_s3;
			z2_s4   <= z2_s3;
			p_s4    <= C5_Q30 - 32'(m4_c >> 30);
			quad_s5 <= quad_s4;
			z_s5    <= z_s4;
			z2_s5   <= z2_s4;
			p_s5    <= C3_Q30 - 32'(m5_c >> 30);
			quad_s6 <= quad_s5;
			z_s6    <= z_s5;
			p_s6    <= C1_Q30 - 32'(m6_c >> 30);
			q_s7    <= q_c;
		end
	end

	assign value = q_s7;

endmodule
`default_nettype wire

// File: sv/compose_model_matrix_4x4_top.sv
`default_nettype none
// Channel   Direction  Payload  Handshake
// cmd       in         cmd_t    cmd_valid / cmd_ready
// ent       out        ent_t    ent_valid / ent_ready
//
// A request runs through 15 pipeline stages (7 for sine and cosine, two per
// rotation, two for scale) and is then emitted as 16 entries, one per cycle while ent_ready is high.
// The output serializer sets the sustained request rate.
// Reset clears the stage valid bits and the serializer; data is not reset.
// A stall holds the whole pipeline; the next matrix loads as the last entry
// of the previous one is taken.
module compose_model_matrix_4x4_top import cmm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic ent_valid,
	input  logic ent_ready,
	output ent_t ent
);

	localparam int LAST = 15;

	logic [LAST:1] vld_s;
	cmd_t item_s [1:13];
	logic en;
	logic load_out;

	logic [ANGLE_BITS-1:0] ang_src [3];
	logic signed [16:0] sin_v [3];
	logic signed [16:0] cos_v [3];
	mat_t rot_in [3];
	mat_t rot_out [3];
	mat_t acc0;
	logic signed [63:0] scl_s14 [3][4];
	mat_t fin_s15;

	logic [3:0] cnt_q;
	logic busy_q;
	mat_t mat_q;

	// Global advance: the pipeline moves unless the last stage is blocked.
	assign load_out  = vld_s[LAST] && (!busy_q || (ent_ready && cnt_q == 4'(LAST)));
	assign en        = !vld_s[LAST] || load_out;
	assign cmd_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAST-1:1], cmd_valid};
		end
	end

	// The request travels alongside its intermediate results.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s[1] <= cmd;
			for (int k = 2; k <= 13; k++) begin
				item_s[k] <= item_s[k-1];
			end
		end
	end

	// Each angle enters its sine units two stages after the previous one.
	always_comb begin
		ang_src[0] = turn_angle(cmd.turn_x);
		ang_src[1] = turn_angle(item_s[2].turn_y);
		ang_src[2] = turn_angle(item_s[4].turn_z);
	end

	for (genvar g = 0; g < 3; g++) begin : g_trig
		cmm_sine u_sin (
			.clk   (clk),
			.en    (en),
			.angle (ang_src[g]),
			.value (sin_v[g])
		);
		cmm_sine u_cos (
			.clk   (clk),
			.en    (en),
			.angle (ang_src[g] + QUARTER_TURN),
			.value (cos_v[g])
		);
	end

	// Translation matrix from the request at stage 7.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc0[i][j] = (i == j) ? Q_ONE : 32'd0;
			end
		end
		acc0[0][3] = item_s[7].move_x;
		acc0[1][3] = item_s[7].move_y;
		acc0[2][3] = item_s[7].move_z;
	end

	assign rot_in[0] = acc0;
	assign rot_in[1] = rot_out[0];
	assign rot_in[2] = rot_out[1];

	// Rotations about x, y and z: rows XR and YR mix, row PR passes.
	// Each takes a multiply stage (_sm) and a sum stage (_ss).
	for (genvar g = 0; g < 3; g++) begin : g_rot
		localparam int XR = (g == 0) ? 1 : ((g == 1) ? 2 : 0);
		localparam int YR = (g == 0) ? 2 : ((g == 1) ? 0 : 1);
		localparam int PR = 3 - XR - YR;

		logic signed [48:0] pxc_sm [4];
		logic signed [48:0] pys_sm [4];
		logic signed [48:0] pxs_sm [4];
		logic signed [48:0] pyc_sm [4];
		row_t pass_sm;
		mat_t acc_ss;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 4; j++) begin
					pxc_sm[j] <= cos_v[g] * $signed(rot_in[g][XR][j]);
					pys_sm[j] <= sin_v[g] * $signed(rot_in[g][YR][j]);
					pxs_sm[j] <= sin_v[g] * $signed(rot_in[g][XR][j]);
					pyc_sm[j] <= cos_v[g] * $signed(rot_in[g][YR][j]);
				end
				pass_sm <= rot_in[g][PR];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 4; j++) begin
					acc_ss[XR][j] <= rnd_sat(65'(pxc_sm[j]) - 65'(pys_sm[j]), 15);
					acc_ss[YR][j] <= rnd_sat(65'(pxs_sm[j]) + 65'(pyc_sm[j]), 15);
				end
				acc_ss[PR] <= pass_sm;
			end
		end

		assign rot_out[g] = acc_ss;
	end

	// Scale: each top row times its stretch factor, then round and saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				scl_s14[0][j] <= item_s[13].stretch_x * $signed(rot_out[2][0][j]);
				scl_s14[1][j] <= item_s[13].stretch_y * $signed(rot_out[2][1][j]);
				scl_s14[2][j] <= item_s[13].stretch_z * $signed(rot_out[2][2][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 4; j++) begin
					fin_s15[i][j] <= rnd_sat(65'(scl_s14[i][j]), FRAC_BITS);
				end
			end
		end
	end

	// Output serializer: walks the 16 entries in row-major order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load_out) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && ent_ready) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(LAST)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mat_q <= fin_s15;
		end
	end

	// The bottom row is constant and never stored.
	always_comb begin
		ent.row_index  = cnt_q[3:2];
		ent.col_index  = cnt_q[1:0];
		ent.last_entry = (cnt_q == 4'(LAST));
		if (cnt_q[3:2] == 2'd3) begin
			ent.entry_value = (cnt_q[1:0] == 2'd3) ? Q_ONE : 32'd0;
		end else begin
			ent.entry_value = mat_q[cnt_q[3:2]][cnt_q[1:0]];
		end
	end

	assign ent_valid = busy_q;

	// A loaded matrix starts at its first entry.
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> busy_q && cnt_q == 4'd0)
		else $error("matrix load did not restart the entry count");

	// The run stays open until its last entry is taken.
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ent_ready && cnt_q != 4'(LAST) |=> busy_q)
		else $error("entry run ended early");

	// A finished matrix that cannot be handed over blocks new requests.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] && !load_out |-> !cmd_ready)
		else $error("request accepted while the pipeline is stalled");

	// Taking the last entry without a new matrix empties the serializer.
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ent_ready && cnt_q == 4'(LAST) && !load_out |=> !busy_q)
		else $error("serializer did not go idle after the last entry");

endmodule
`default_nettype wire
